FILE: src/bpa_pkg.sv
// Shared types, defaults and state codes for the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  // Default pool geometry.
  localparam int PAGE_COUNT_DEF = 4096;
  localparam int MAX_ORDER_DEF  = 11;

  // Fixed widths of the request and result words.
  localparam int PAGE_FIELD_W = 12;
  localparam int REQ_ORDER_W  = 4;
  localparam int CNT_W        = 13;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [REQ_ORDER_W-1:0]  req_order;
    logic [PAGE_FIELD_W-1:0] page_index;
  } in_t;

  typedef struct packed {
    logic                    ok;
    logic [PAGE_FIELD_W-1:0] alloc_page;
    logic [CNT_W-1:0]        free_total;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UNLINK,
    S_SPLIT,
    S_PUSH_A,
    S_PUSH_B,
    S_FINISH_ALLOC,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_REPORT
  } state_t;

endpackage

FILE: src/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: sequencer, list heads and page stores.
// An allocate scans the order lists upward from the requested order, unlinks
// the first block found and splits it down to that order; a failed scan or a
// too large order reports failure. A free merges the block with free buddies of
// its order and pushes the result; a double free reports failure.
// One request at a time. After reset a clearing pass zeroes the page flags while
// busy stays high. The receiver cannot stall; each result word shows once.
`timescale 1ns / 1ps

module buddy_page_allocator_top #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::in_t  in_req,
  output logic          out_valid,
  output bpa_pkg::out_t out_res
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int LNK_W  = PAGE_W + 1;
  localparam int ORD_W  = $clog2(MAX_ORDER);
  localparam int META_W = ORD_W + 1;
  localparam int SUM_W  = ((PAGE_W > MAX_ORDER) ? PAGE_W : MAX_ORDER) + 1;
  localparam int CNT_W  = bpa_pkg::CNT_W;
  localparam logic [LNK_W-1:0] NIL = LNK_W'(PAGE_COUNT);
  localparam logic [ORD_W-1:0] ORD_TOP = ORD_W'(MAX_ORDER - 1);

  bpa_pkg::state_t state_r, state_nxt;

  logic [ORD_W-1:0]  ord_r;
  logic [ORD_W-1:0]  req_r;
  logic [PAGE_W-1:0] pg_r;
  logic [PAGE_W-1:0] blk_r;
  logic [LNK_W-1:0]  h_r;
  logic              alloc_r;
  logic              ok_r;
  logic [PAGE_W-1:0] page_r;
  logic [CNT_W-1:0]  total_r;
  logic [PAGE_W-1:0] clr_r;
  logic [LNK_W-1:0]  heads_r [MAX_ORDER];
  logic [CNT_W-1:0]  counts_r [MAX_ORDER];

  // Page store ports.
  logic              meta_we, next_we, prev_we;
  logic [PAGE_W-1:0] meta_waddr, next_waddr, prev_waddr;
  logic [PAGE_W-1:0] meta_raddr, next_raddr, prev_raddr;
  logic [META_W-1:0] meta_wdata, meta_rd;
  logic [LNK_W-1:0]  next_wdata, prev_wdata, next_rd, prev_rd;

  // Shared address and order arithmetic.
  logic [LNK_W-1:0]  head_cur;
  logic [ORD_W-1:0]  ord_m1;
  logic [SUM_W-1:0]  split_pg;
  logic [SUM_W-1:0]  buddy_pg;
  logic [SUM_W-1:0]  in_pg;
  logic              req_ok;
  logic              meta_free;
  logic [ORD_W-1:0]  meta_ord;
  logic [CNT_W-1:0]  req_pages;
  logic [CNT_W-1:0]  rd_pages;

  assign head_cur  = heads_r[ord_r];
  assign ord_m1    = ord_r - ORD_W'(1);
  assign split_pg  = SUM_W'(blk_r) + (SUM_W'(1) << ord_m1);
  assign buddy_pg  = SUM_W'(pg_r) ^ (SUM_W'(1) << ord_r);
  assign in_pg     = SUM_W'(in_req.page_index);
  assign req_ok    = (int'(in_req.req_order) < MAX_ORDER);
  assign meta_free = meta_rd[META_W-1];
  assign meta_ord  = meta_rd[ORD_W-1:0];
  assign req_pages = CNT_W'(1) << req_r;
  assign rd_pages  = CNT_W'(1) << meta_ord;

  bpa_ram #(.WIDTH(META_W), .DEPTH(PAGE_COUNT)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rd)
  );

  bpa_ram #(.WIDTH(LNK_W), .DEPTH(PAGE_COUNT)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rd)
  );

  bpa_ram #(.WIDTH(LNK_W), .DEPTH(PAGE_COUNT)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(prev_rd)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        if (int'(clr_r) == PAGE_COUNT - 1) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (start) begin
          if (in_req.kind == bpa_pkg::KIND_ALLOC) begin
            state_nxt = req_ok ? bpa_pkg::S_SCAN : bpa_pkg::S_REPORT;
          end else begin
            state_nxt = (in_pg < SUM_W'(PAGE_COUNT)) ? bpa_pkg::S_FREE_CHK
                                                      : bpa_pkg::S_REPORT;
          end
        end
      end
      bpa_pkg::S_SCAN: begin
        if (head_cur < NIL) state_nxt = bpa_pkg::S_UNLINK;
        else if (ord_r == ORD_TOP) state_nxt = bpa_pkg::S_REPORT;
      end
      bpa_pkg::S_UNLINK: state_nxt = bpa_pkg::S_SPLIT;
      bpa_pkg::S_SPLIT: begin
        if (ord_r > req_r) begin
          if (split_pg < SUM_W'(PAGE_COUNT)) state_nxt = bpa_pkg::S_PUSH_A;
        end else begin
          state_nxt = bpa_pkg::S_FINISH_ALLOC;
        end
      end
      bpa_pkg::S_PUSH_A: state_nxt = bpa_pkg::S_PUSH_B;
      bpa_pkg::S_PUSH_B: state_nxt = alloc_r ? bpa_pkg::S_SPLIT : bpa_pkg::S_REPORT;
      bpa_pkg::S_FINISH_ALLOC: state_nxt = bpa_pkg::S_REPORT;
      bpa_pkg::S_FREE_CHK: begin
        state_nxt = meta_free ? bpa_pkg::S_REPORT : bpa_pkg::S_MERGE_RD;
      end
      bpa_pkg::S_MERGE_RD: begin
        if (ord_r == ORD_TOP || buddy_pg >= SUM_W'(PAGE_COUNT)) begin
          state_nxt = bpa_pkg::S_PUSH_A;
        end else begin
          state_nxt = bpa_pkg::S_MERGE_CHK;
        end
      end
      bpa_pkg::S_MERGE_CHK: begin
        state_nxt = (meta_free && meta_ord == ord_r) ? bpa_pkg::S_MERGE_RD
                                                      : bpa_pkg::S_PUSH_A;
      end
      bpa_pkg::S_REPORT: state_nxt = bpa_pkg::S_IDLE;
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // Store controls and port outputs.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = pg_r;
    meta_wdata = '0;
    meta_raddr = PAGE_W'(buddy_pg);
    next_we    = 1'b0;
    next_waddr = pg_r;
    next_wdata = head_cur;
    next_raddr = PAGE_W'(buddy_pg);
    prev_we    = 1'b0;
    prev_waddr = pg_r;
    prev_wdata = NIL;
    prev_raddr = PAGE_W'(buddy_pg);
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
      end
      bpa_pkg::S_IDLE: begin
        meta_raddr = PAGE_W'(in_req.page_index);
      end
      bpa_pkg::S_SCAN: begin
        next_raddr = PAGE_W'(head_cur);
      end
      bpa_pkg::S_UNLINK: begin
        // Detach the head block; its successor loses its back link.
        prev_we    = (next_rd < NIL);
        prev_waddr = PAGE_W'(next_rd);
        prev_wdata = NIL;
      end
      bpa_pkg::S_PUSH_A: begin
        meta_we    = 1'b1;
        meta_wdata = {1'b1, ord_r};
        next_we    = 1'b1;
        prev_we    = 1'b1;
      end
      bpa_pkg::S_PUSH_B: begin
        prev_we    = (h_r < NIL);
        prev_waddr = PAGE_W'(h_r);
        prev_wdata = LNK_W'(pg_r);
      end
      bpa_pkg::S_FINISH_ALLOC: begin
        meta_we    = 1'b1;
        meta_waddr = blk_r;
        meta_wdata = {1'b0, req_r};
      end
      bpa_pkg::S_FREE_CHK: begin
        meta_we = !meta_free;
      end
      bpa_pkg::S_MERGE_CHK: begin
        // Unlink the buddy from its list, whether it is the head or further in.
        if (meta_free && meta_ord == ord_r) begin
          meta_we    = 1'b1;
          meta_waddr = blk_r;
          next_we    = (prev_rd < NIL);
          next_waddr = PAGE_W'(prev_rd);
          next_wdata = next_rd;
          prev_we    = (next_rd < NIL);
          prev_waddr = PAGE_W'(next_rd);
          prev_wdata = prev_rd;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy               = (state_r != bpa_pkg::S_IDLE);
  assign out_valid          = (state_r == bpa_pkg::S_REPORT);
  assign out_res.ok         = ok_r;
  assign out_res.alloc_page = bpa_pkg::PAGE_FIELD_W'(page_r);
  assign out_res.free_total = total_r;

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
      ok_r    <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        heads_r[i]  <= NIL;
        counts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        bpa_pkg::S_CLEAR: begin
          clr_r <= clr_r + PAGE_W'(1);
        end
        bpa_pkg::S_IDLE: begin
          ok_r    <= 1'b0;
          page_r  <= '0;
          alloc_r <= (in_req.kind == bpa_pkg::KIND_ALLOC);
          ord_r   <= ORD_W'(in_req.req_order);
          req_r   <= ORD_W'(in_req.req_order);
          pg_r    <= PAGE_W'(in_req.page_index);
        end
        bpa_pkg::S_SCAN: begin
          blk_r <= PAGE_W'(head_cur);
          if (!(head_cur < NIL) && ord_r != ORD_TOP) ord_r <= ord_r + ORD_W'(1);
        end
        bpa_pkg::S_UNLINK: begin
          heads_r[ord_r]  <= next_rd;
          counts_r[ord_r] <= counts_r[ord_r] - CNT_W'(1);
        end
        bpa_pkg::S_SPLIT: begin
          if (ord_r > req_r) begin
            ord_r <= ord_m1;
            pg_r  <= PAGE_W'(split_pg);
          end
        end
        bpa_pkg::S_PUSH_A: begin
          h_r             <= head_cur;
          heads_r[ord_r]  <= LNK_W'(pg_r);
          counts_r[ord_r] <= counts_r[ord_r] + CNT_W'(1);
        end
        bpa_pkg::S_FINISH_ALLOC: begin
          ok_r    <= 1'b1;
          page_r  <= blk_r;
          total_r <= total_r - req_pages;
        end
        bpa_pkg::S_FREE_CHK: begin
          if (!meta_free) begin
            ok_r    <= 1'b1;
            ord_r   <= meta_ord;
            total_r <= total_r + rd_pages;
          end
        end
        bpa_pkg::S_MERGE_RD: begin
          blk_r <= PAGE_W'(buddy_pg);
        end
        bpa_pkg::S_MERGE_CHK: begin
          if (meta_free && meta_ord == ord_r) begin
            if (!(prev_rd < NIL)) heads_r[ord_r] <= next_rd;
            counts_r[ord_r] <= counts_r[ord_r] - CNT_W'(1);
            pg_r            <= pg_r & ~(PAGE_W'(1) << ord_r);
            ord_r           <= ord_r + ORD_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A result word shows for one cycle only.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted request keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // A failed request reports page zero.
  a_fail_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.ok) |-> (out_res.alloc_page == '0))
    else $error("failed request reports a page");

  // The free total changes only when a request succeeds.
  a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.ok && $past(state_r) != bpa_pkg::S_IDLE
     && $past(state_r) != bpa_pkg::S_CLEAR) |-> $stable(out_res.free_total))
    else $error("free total changed on a failed request");

endmodule

FILE: src/bpa_ram.sv
// Single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = bpa_pkg::PAGE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
